// File: design/ipmt_pkg.sv
// Package for the interface prefix match table.
// Holds table sizing, item kind codes, entry layout and the controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipmt_pkg;

    // Table sizing
    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LAST_IDX = ENTRIES - 1;

    // Field widths fixed by the item format
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 5;
    localparam int ADDR_W   = 64;
    localparam int PREFIX_W = 8;
    localparam int OWNER_W  = 16;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    // Prefix limits per family
    localparam logic [PREFIX_W-1:0] V4_MAX_PREFIX = 8'd32;
    localparam logic [PREFIX_W-1:0] V6_MAX_PREFIX = 8'd128;

    // One stored table entry (valid bits live in flops, outside the RAM)
    typedef struct packed {
        logic                is_v6;
        logic [ADDR_W-1:0]   addr_hi;
        logic [ADDR_W-1:0]   addr_lo;
        logic [PREFIX_W-1:0] prefix;
        logic [OWNER_W-1:0]  owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Controller to datapath
    typedef struct packed {
        logic             wr;        // write entry at i_slot
        logic             clr;       // clear valid bit at i_slot
        logic             qload;     // capture lookup query
        logic [IDX_W-1:0] rd_addr;   // scan read address
        logic             out_zero;  // load an all-zero result
        logic             out_hit;   // load the matching entry as result
        logic [IDX_W-1:0] res_slot;  // slot of the matching entry
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;                   // entry in compare stage matches query
    } t_dp_sts;

endpackage

`default_nettype wire

// File: design/interface_prefix_match_table.sv
// Top level of the interface prefix match table.
// Joins the controller and the datapath. Depends on ipmt_pkg, ipmt_ctrl,
// ipmt_datapath and ipmt_ram.
//
//   Channel   Dir   Handshake                   Beat contents
//   input     in    i_in_valid / o_in_ready     i_kind i_slot i_is_v6 i_address_hi
//                                               i_address_lo i_prefix_len i_interface_id
//   output    out   o_out_valid / i_out_ready   o_found o_match_interface o_match_slot
//
// Write, clear and unused kinds give a result that is valid in the cycle after the beat is taken.
// A lookup scans the entry RAM one slot per cycle, comparing each entry in the cycle
// after its read, and ends at the first match or after the last slot.
// Reset (synchronous, active low) clears all valid bits at once; no clearing pass.
// A new beat is taken only when idle and the result register is empty or being taken.
`timescale 1ns / 1ps
`default_nettype none

module interface_prefix_match_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ipmt_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [ipmt_pkg::SLOT_W-1:0]   i_slot,
    input  wire logic                          i_is_v6,
    input  wire logic [ipmt_pkg::ADDR_W-1:0]   i_address_hi,
    input  wire logic [ipmt_pkg::ADDR_W-1:0]   i_address_lo,
    input  wire logic [ipmt_pkg::PREFIX_W-1:0] i_prefix_len,
    input  wire logic [ipmt_pkg::OWNER_W-1:0]  i_interface_id,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_found,
    output logic [ipmt_pkg::OWNER_W-1:0]       o_match_interface,
    output logic [ipmt_pkg::SLOT_W-1:0]        o_match_slot
);

    ipmt_pkg::t_dp_cmd dp_cmd;
    ipmt_pkg::t_dp_sts dp_sts;

    ipmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_slot      (i_slot),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    ipmt_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_slot            (i_slot),
        .i_is_v6           (i_is_v6),
        .i_address_hi      (i_address_hi),
        .i_address_lo      (i_address_lo),
        .i_prefix_len      (i_prefix_len),
        .i_interface_id    (i_interface_id),
        .o_sts             (dp_sts),
        .o_found           (o_found),
        .o_match_interface (o_match_interface),
        .o_match_slot      (o_match_slot)
    );

endmodule

`default_nettype wire

// File: design/ipmt_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ipmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/ipmt_datapath.sv
// Datapath of the prefix match table: entry RAM, valid bits, query registers,
// prefix mask compare and result registers. Depends on ipmt_pkg and ipmt_ram.
`timescale 1ns / 1ps
`default_nettype none

module ipmt_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ipmt_pkg::t_dp_cmd              i_cmd,
    input  wire logic [ipmt_pkg::SLOT_W-1:0]    i_slot,
    input  wire logic                           i_is_v6,
    input  wire logic [ipmt_pkg::ADDR_W-1:0]    i_address_hi,
    input  wire logic [ipmt_pkg::ADDR_W-1:0]    i_address_lo,
    input  wire logic [ipmt_pkg::PREFIX_W-1:0]  i_prefix_len,
    input  wire logic [ipmt_pkg::OWNER_W-1:0]   i_interface_id,
    output ipmt_pkg::t_dp_sts                   o_sts,
    output logic                                o_found,
    output logic [ipmt_pkg::OWNER_W-1:0]        o_match_interface,
    output logic [ipmt_pkg::SLOT_W-1:0]         o_match_slot
);

    logic [ipmt_pkg::ENTRIES-1:0]   r_valid;
    logic                           r_rd_valid;
    logic                           r_q_v6;
    logic [ipmt_pkg::ADDR_W-1:0]    r_q_hi;
    logic [ipmt_pkg::ADDR_W-1:0]    r_q_lo;
    logic                           r_found;
    logic [ipmt_pkg::OWNER_W-1:0]   r_match_if;
    logic [ipmt_pkg::SLOT_W-1:0]    r_match_slot;

    logic [ipmt_pkg::IDX_W-1:0]     wr_idx;
    ipmt_pkg::t_entry               wr_entry;
    logic [ipmt_pkg::ENTRY_W-1:0]   rd_word;
    ipmt_pkg::t_entry               rd_entry;
    logic [ipmt_pkg::PREFIX_W-1:0]  max_prefix;
    logic [127:0]                   mask128;
    logic [31:0]                    mask32;
    logic                           eq_v6;
    logic                           eq_v4;

    assign wr_idx = ipmt_pkg::IDX_W'(i_slot);

    // Entry to write: IPv4 drops the upper address bits, prefix is clamped
    always_comb begin
        max_prefix       = i_is_v6 ? ipmt_pkg::V6_MAX_PREFIX : ipmt_pkg::V4_MAX_PREFIX;
        wr_entry.is_v6   = i_is_v6;
        wr_entry.addr_hi = i_is_v6 ? i_address_hi : '0;
        wr_entry.addr_lo = i_is_v6 ? i_address_lo : {32'd0, i_address_lo[31:0]};
        wr_entry.prefix  = (i_prefix_len > max_prefix) ? max_prefix : i_prefix_len;
        wr_entry.owner   = i_interface_id;
    end

    ipmt_ram #(
        .WIDTH (ipmt_pkg::ENTRY_W),
        .DEPTH (ipmt_pkg::ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (wr_idx),
        .i_wdata (wr_entry),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rd_word)
    );

    assign rd_entry = ipmt_pkg::t_entry'(rd_word);

    // Valid bits, plus the bit of the slot being read, aligned with RAM data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_valid[wr_idx] <= 1'b1;
            end else if (i_cmd.clr) begin
                r_valid[wr_idx] <= 1'b0;
            end
            r_rd_valid <= r_valid[i_cmd.rd_addr];
        end
    end

    // Query capture; IPv4 queries keep only the low 32 bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.qload) begin
            r_q_v6 <= i_is_v6;
            r_q_hi <= i_is_v6 ? i_address_hi : '0;
            r_q_lo <= i_is_v6 ? i_address_lo : {32'd0, i_address_lo[31:0]};
        end
    end

    // Prefix masks: top prefix bits set; a shift of the full width yields zero
    always_comb begin
        mask128 = ~({128{1'b1}} >> rd_entry.prefix);
        mask32  = ~(32'hffff_ffff >> rd_entry.prefix);
        eq_v6   = (({r_q_hi, r_q_lo} & mask128) ==
                   ({rd_entry.addr_hi, rd_entry.addr_lo} & mask128));
        eq_v4   = ((r_q_lo[31:0] & mask32) == (rd_entry.addr_lo[31:0] & mask32));
    end

    assign o_sts.hit = r_rd_valid && (rd_entry.is_v6 == r_q_v6) &&
                       (r_q_v6 ? eq_v6 : eq_v4);

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_hit) begin
            r_found      <= 1'b1;
            r_match_if   <= rd_entry.owner;
            r_match_slot <= ipmt_pkg::SLOT_W'(i_cmd.res_slot);
        end else if (i_cmd.out_zero) begin
            r_found      <= 1'b0;
            r_match_if   <= '0;
            r_match_slot <= '0;
        end
    end

    assign o_found           = r_found;
    assign o_match_interface = r_match_if;
    assign o_match_slot      = r_match_slot;

endmodule

`default_nettype wire

// File: design/ipmt_ctrl.sv
// Controller of the prefix match table: handshakes, item decode and the slot
// scan sequencer. Depends on ipmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipmt_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ipmt_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [ipmt_pkg::SLOT_W-1:0]   i_slot,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output ipmt_pkg::t_dp_cmd                  o_cmd,
    input  wire ipmt_pkg::t_dp_sts             i_sts
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state                      r_state, n_state;
    logic [ipmt_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic                        r_pend, n_pend;
    logic [ipmt_pkg::IDX_W-1:0]  r_pend_slot, n_pend_slot;
    logic                        r_out_valid, n_out_valid;

    logic out_free;
    logic accept;
    logic slot_ok;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign accept     = o_in_ready && i_in_valid;
    assign slot_ok    = ({1'b0, i_slot} < (ipmt_pkg::SLOT_W + 1)'(ipmt_pkg::ENTRIES));

    // Next state and datapath commands
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pend_slot  = r_pend_slot;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd        = '0;
        o_cmd.rd_addr  = r_idx;
        o_cmd.res_slot = r_pend_slot;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_kind == ipmt_pkg::KIND_LOOKUP) begin
                        o_cmd.qload = 1'b1;
                        n_state     = ST_SCAN;
                        n_idx       = '0;
                        n_pend      = 1'b0;
                    end else begin
                        o_cmd.wr       = (i_kind == ipmt_pkg::KIND_WRITE) && slot_ok;
                        o_cmd.clr      = (i_kind == ipmt_pkg::KIND_CLEAR) && slot_ok;
                        o_cmd.out_zero = 1'b1;
                        n_out_valid    = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                // One slot read per cycle; each slot is compared in the cycle after its read
                if (r_pend && i_sts.hit) begin
                    o_cmd.out_hit = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end else if (r_pend &&
                             (r_pend_slot == ipmt_pkg::IDX_W'(ipmt_pkg::LAST_IDX))) begin
                    o_cmd.out_zero = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_pend      = 1'b1;
                    n_pend_slot = r_idx;
                    n_idx       = r_idx + ipmt_pkg::IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_pend_slot <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_pend_slot <= n_pend_slot;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
